// File: design/ipd_pkg.sv
// Shared types and constants for the IPD frame payload extractor.
// Holds the parse phase encoding, the matched characters and the default length width.
// Depends on nothing; every other design file imports it.
package ipd_pkg;

	localparam int BYTE_W = 8;
	localparam int LENGTH_BITS_DEF = 16;

	localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [BYTE_W-1:0] CH_I     = 8'h49;
	localparam logic [BYTE_W-1:0] CH_P     = 8'h50;
	localparam logic [BYTE_W-1:0] CH_D     = 8'h44;
	localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
	localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
	localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;

	typedef enum logic [8:0] {
		PH_IDLE   = 9'b000000001,
		PH_PLUS   = 9'b000000010,
		PH_I      = 9'b000000100,
		PH_P      = 9'b000001000,
		PH_D      = 9'b000010000,
		PH_COMMA1 = 9'b000100000,
		PH_ID     = 9'b001000000,
		PH_LEN    = 9'b010000000,
		PH_DATA   = 9'b100000000
	} phase_t;

	typedef struct packed {
		phase_t phase;
		logic   emit;
		logic   last;
	} step_ctl_t;

endpackage

// File: design/ipd_rx_if.sv
// Handshake channel that carries one received serial byte per word.
// Depends on ipd_pkg for the byte width.
interface ipd_rx_if import ipd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

// File: design/ipd_payload_if.sv
// Handshake channel that carries one extracted payload byte and its last flag per word.
// Depends on ipd_pkg for the byte width.
interface ipd_payload_if import ipd_pkg::*; ;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] payload_byte;
	logic              payload_last;

	modport source(output valid, output payload_byte, output payload_last, input ready);
	modport sink(input valid, input payload_byte, input payload_last, output ready);
endinterface

// File: design/ipd_step.sv
// Next-state logic of the frame parser: phase transition, length accumulation and payload count.
// Purely combinational; depends on ipd_pkg.
module ipd_step import ipd_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  phase_t                 phase,
	input  logic [LENGTH_BITS-1:0] remaining,
	input  logic [BYTE_W-1:0]      rx_byte,
	output step_ctl_t              ctl,
	output logic [LENGTH_BITS-1:0] remaining_nxt
);

	localparam int SUM_W = LENGTH_BITS + 5;

	logic [SUM_W-1:0]       acc_sum;
	logic [SUM_W-1:0]       acc_diff;
	logic [LENGTH_BITS-1:0] acc_len;
	logic [LENGTH_BITS-1:0] dec_len;

	// The sum is len * 10 + byte, then '0' is taken off with clamping at both ends.
	always_comb begin
		acc_sum = SUM_W'({remaining, 3'b000}) + SUM_W'({remaining, 1'b0}) + SUM_W'(rx_byte);
		acc_diff = acc_sum - SUM_W'(CH_ZERO);
		if (acc_sum < SUM_W'(CH_ZERO)) begin
			acc_len = '0;
		end else if (acc_diff[SUM_W-1:LENGTH_BITS] != '0) begin
			acc_len = '1;
		end else begin
			acc_len = acc_diff[LENGTH_BITS-1:0];
		end
		dec_len = remaining - LENGTH_BITS'(1);
	end

	always_comb begin
		ctl.phase = phase;
		ctl.emit = 1'b0;
		ctl.last = 1'b0;
		remaining_nxt = remaining;
		if (phase == PH_DATA) begin
			if (remaining == '0) begin
				ctl.phase = PH_IDLE;
			end else begin
				remaining_nxt = dec_len;
				ctl.emit = 1'b1;
				ctl.last = (dec_len == '0);
				if (dec_len == '0) begin
					ctl.phase = PH_IDLE;
				end
			end
		end else if (rx_byte == CH_PLUS) begin
			ctl.phase = PH_PLUS;
		end else begin
			unique case (phase)
				PH_IDLE: begin
				end
				PH_PLUS: begin
					if (rx_byte == CH_I) ctl.phase = PH_I;
				end
				PH_I: begin
					if (rx_byte == CH_P) ctl.phase = PH_P;
				end
				PH_P: begin
					if (rx_byte == CH_D) ctl.phase = PH_D;
				end
				PH_D: begin
					if (rx_byte == CH_COMMA) ctl.phase = PH_COMMA1;
				end
				PH_COMMA1: begin
					if (rx_byte != CH_COMMA) ctl.phase = PH_ID;
				end
				PH_ID: begin
					if (rx_byte == CH_COMMA) begin
						ctl.phase = PH_LEN;
						remaining_nxt = '0;
					end
				end
				PH_LEN: begin
					if (rx_byte == CH_COLON) begin
						ctl.phase = (remaining == '0) ? PH_IDLE : PH_DATA;
					end else begin
						remaining_nxt = acc_len;
					end
				end
				default: begin
					ctl.phase = PH_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/ipd_frame_payload_extractor.sv
// Top level of the IPD frame payload extractor: input stage, parser state and result register.
// Depends on ipd_pkg, ipd_rx_if, ipd_payload_if and ipd_step.
//
// The rx channel takes one serial byte from the Wi-Fi module link per word. The block
// looks for frames of the form +IPD,<id>,<decimal length>:<payload> and sends every
// payload byte out on the payload channel, with payload_last set on the final byte of
// the declared length. Header bytes and bytes outside a frame produce no word.
// A byte is registered in the input stage at acceptance and parsed when it advances
// against the phase and length registers; its payload word, if any, is loaded into the
// output register as the byte advances, while a stall holds the byte in the input stage.
// With the receiver ready the block takes one byte every cycle, steadily.
// A '+' restarts header matching in any header phase; inside the payload it is data.
// A zero declared length returns the parser to idle with no word.
// Asynchronous reset returns the parser to idle with a zero count and empties both
// the input stage and the output register.
// When the receiver stalls, the output register holds its word, the input stage holds
// one more byte, and rx.ready drops until the word is taken.
module ipd_frame_payload_extractor import ipd_pkg::*; #(
	parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	ipd_rx_if.sink         rx,
	ipd_payload_if.source  payload
);

	logic                   valid_s1;
	logic [BYTE_W-1:0]      byte_s1;
	phase_t                 phase_q;
	logic [LENGTH_BITS-1:0] remaining_q;
	logic                   out_valid_q;
	logic [BYTE_W-1:0]      out_byte_q;
	logic                   out_last_q;

	step_ctl_t              ctl;
	logic [LENGTH_BITS-1:0] remaining_nxt;
	logic                   advance;
	logic                   rx_take;

	ipd_step #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_step (
		.phase(phase_q),
		.remaining(remaining_q),
		.rx_byte(byte_s1),
		.ctl(ctl),
		.remaining_nxt(remaining_nxt)
	);

	assign advance = valid_s1 && (!out_valid_q || payload.ready);
	assign rx.ready = !valid_s1 || advance;
	assign rx_take = rx.valid && rx.ready;

	assign payload.valid = out_valid_q;
	assign payload.payload_byte = out_byte_q;
	assign payload.payload_last = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx_take) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			remaining_q <= '0;
		end else if (advance) begin
			phase_q <= ctl.phase;
			remaining_q <= remaining_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (payload.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && ctl.emit) begin
			out_byte_q <= byte_s1;
			out_last_q <= ctl.last;
		end
	end

	a_data_has_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DATA) |-> (remaining_q != '0))
		else $error("payload phase with a zero byte count");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && ctl.emit && ctl.last) |=> (phase_q == PH_IDLE))
		else $error("parser did not return to idle after the last payload byte");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!rx.ready |-> (valid_s1 && out_valid_q))
		else $error("input stalled without a held word");

	a_word_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("payload word appeared without a parsed byte");

endmodule
